/* rtl/spic_pkg.sv */
// shared constants, types and helpers for the pair interaction counter
package spic_pkg;

    localparam int MAX_POINTS = 256;
    localparam int MAX_DIMS   = 4;

    localparam int COORD_W = 16;
    localparam int PT_W    = MAX_DIMS * COORD_W;
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int PAIR_W  = 15;
    localparam int CNT9_W  = 9;
    localparam int RAD_W   = 36;
    localparam int LOGP_W  = 32;
    localparam int LOG_W   = 48;
    localparam int DIMS_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 64;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;

    localparam logic [PAIR_W-1:0]        PAIR_MAX = '1;
    localparam logic signed [LOG_W-1:0]  LOG_MIN  = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic signed [LOG_W-1:0]  LOG_MAX  = {1'b0, {(LOG_W-1){1'b1}}};

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_RADIUS_SQ  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LOG_BETA   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LN_GAMMA   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DIMS       = 3'd3;
    localparam logic [CIDX_W-1:0] REG_RANGE_LOW  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_RANGE_HIGH = 3'd5;

    typedef struct packed {
        logic busy;
        logic hit_vld;
        logic hit;
    } t_dist_stat;

    typedef struct packed {
        logic                    vld;
        logic                    sat;
        logic signed [LOG_W-1:0] value;
    } t_log_res;

    typedef struct packed {
        logic                    saturated;
        logic                    store_full;
        logic                    out_of_range;
        logic [PAIR_W-1:0]       pair_count;
        logic [CNT9_W-1:0]       point_count;
        logic [CNT9_W-1:0]       neighbor_count;
        logic signed [LOG_W-1:0] log_value;
    } t_result;

    // lanes that take part: zero acts as one, above MAX_DIMS acts as MAX_DIMS
    function automatic logic [MAX_DIMS-1:0] dims_mask(input logic [DIMS_W-1:0] dims);
        logic [DIMS_W:0]   n;
        logic [MAX_DIMS-1:0] m;
        n = {1'b0, dims};
        if (n == '0) begin
            n = (DIMS_W+1)'(1);
        end
        if (n > (DIMS_W+1)'(MAX_DIMS)) begin
            n = (DIMS_W+1)'(MAX_DIMS);
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            m[d] = ((DIMS_W+1)'(d) < n);
        end
        return m;
    endfunction

    // count clipped to the 9-bit result fields
    function automatic logic [CNT9_W-1:0] sat_cnt9(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd511) ? 9'd511 : w[CNT9_W-1:0];
    endfunction

endpackage

/* rtl/strauss_pair_interaction_count.sv */
// top level: command sequencer around the point store, distance unit and log unit
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  command   | i_s_tvalid/o_s_tready   | i_s_tuser: command; i_s_tdata: coords 0..3
//  result    | o_m_tvalid/i_m_tready   | o_m_tdata: log, counts; o_m_tuser: flags
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  insert and in-range query: the accept, one store read per held point, the end
//  of the scan, the drain of the read and distance pipeline, the log unit and
//  the output load; clear, unused command and out-of-range query go straight to
//  the output load, a refused insert passes through the log unit first
//  synchronous active-low reset empties the set and loads register defaults;
//  a result stall holds the output load and the next item with it; a loaded result waits while the next item runs
module strauss_pair_interaction_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command items
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [63:0]                      i_s_tdata,   // coord_0, coord_1, coord_2, coord_3
    input  logic [1:0]                       i_s_tuser,   // command
    // result items
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // log_value, neighbor_count, point_count, pair_count, 7 zero bits
    output logic [87:0]                      o_m_tdata,
    output logic [2:0]                       o_m_tuser,   // out_of_range, store_full, saturated
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spic_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [spic_pkg::CDATA_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_LOG,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                              r_state, n_state;
    logic [1:0]                          r_cmd, n_cmd;
    logic [spic_pkg::PT_W-1:0]           r_pt, n_pt;
    logic [spic_pkg::CNT_W-1:0]          r_addr, n_addr;
    logic                                r_rd_vld, n_rd_vld;
    logic [spic_pkg::CNT_W-1:0]          r_neigh, n_neigh;
    logic [spic_pkg::CNT_W-1:0]          r_held, n_held;
    logic [spic_pkg::PAIR_W-1:0]         r_pairs, n_pairs;
    spic_pkg::t_result                   r_res, n_res;
    spic_pkg::t_result                   r_out, n_out;
    logic                                r_out_vld, n_out_vld;

    // configuration registers
    logic [spic_pkg::RAD_W-1:0]          r_radius;
    logic signed [spic_pkg::LOGP_W-1:0]  r_beta;
    logic signed [spic_pkg::LOGP_W-1:0]  r_gamma;
    logic [spic_pkg::DIMS_W-1:0]         r_dims;
    logic [spic_pkg::PT_W-1:0]           r_lo;
    logic [spic_pkg::PT_W-1:0]           r_hi;

    logic [spic_pkg::MAX_DIMS-1:0]       dim_mask;
    logic                                oor;
    logic                                accept;
    logic                                issue;
    logic                                ram_we;
    logic [spic_pkg::PT_W-1:0]           ram_rdata;
    logic                                log_start;
    logic [spic_pkg::CNT_W-1:0]          log_a;
    logic [spic_pkg::PAIR_W-1:0]         log_b;
    logic [31:0]                         pair_sum;
    spic_pkg::t_dist_stat                dist_stat;
    spic_pkg::t_log_res                  log_res;

    assign dim_mask    = spic_pkg::dims_mask(r_dims);
    assign accept      = i_s_tvalid & o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // bounds check of the incoming candidate, signed per used lane
    always_comb begin
        oor = 1'b0;
        for (int d = 0; d < spic_pkg::MAX_DIMS; d++) begin
            if (dim_mask[d] &&
                (($signed(i_s_tdata[d*spic_pkg::COORD_W +: spic_pkg::COORD_W]) <
                  $signed(r_lo[d*spic_pkg::COORD_W +: spic_pkg::COORD_W])) ||
                 ($signed(i_s_tdata[d*spic_pkg::COORD_W +: spic_pkg::COORD_W]) >
                  $signed(r_hi[d*spic_pkg::COORD_W +: spic_pkg::COORD_W])))) begin
                oor = 1'b1;
            end
        end
    end

    // store read: one held point per cycle while scanning
    assign issue    = (r_state == S_SCAN) && (r_addr != r_held);
    assign pair_sum = 32'(r_pairs) + 32'(r_neigh);

    assign log_start = (r_state == S_LOG);
    assign log_a     = (r_cmd == spic_pkg::CMD_INSERT) ? r_held : '0;
    assign log_b     = (r_cmd == spic_pkg::CMD_INSERT) ? r_pairs : spic_pkg::PAIR_W'(r_neigh);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pt      = r_pt;
        n_addr    = r_addr;
        n_rd_vld  = issue;
        n_neigh   = r_neigh;
        n_held    = r_held;
        n_pairs   = r_pairs;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        ram_we    = 1'b0;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        // count hits arriving from the distance pipeline
        if (dist_stat.hit_vld && dist_stat.hit) begin
            n_neigh = r_neigh + spic_pkg::CNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd               = i_s_tuser;
                    n_pt                = i_s_tdata;
                    n_addr              = '0;
                    n_neigh             = '0;
                    n_res               = '0;
                    n_res.point_count   = spic_pkg::sat_cnt9(r_held);
                    n_res.pair_count    = r_pairs;
                    case (i_s_tuser)
                        spic_pkg::CMD_CLEAR: begin
                            n_held            = '0;
                            n_pairs           = '0;
                            n_res.point_count = '0;
                            n_res.pair_count  = '0;
                            n_state           = S_OUT;
                        end
                        spic_pkg::CMD_INSERT: begin
                            if (r_held >= spic_pkg::CNT_W'(spic_pkg::MAX_POINTS)) begin
                                // refused: report density of the current set
                                n_res.store_full = 1'b1;
                                n_state          = S_LOG;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        spic_pkg::CMD_QUERY: begin
                            if (oor) begin
                                n_res.out_of_range = 1'b1;
                                n_res.log_value    = spic_pkg::LOG_MIN;
                                n_state            = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + spic_pkg::CNT_W'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // interlock: store write waits until all reads have retired
                if (!r_rd_vld && !dist_stat.busy) begin
                    n_res.neighbor_count = spic_pkg::sat_cnt9(r_neigh);
                    if (r_cmd == spic_pkg::CMD_INSERT) begin
                        ram_we  = 1'b1;
                        n_held  = r_held + spic_pkg::CNT_W'(1);
                        n_pairs = (pair_sum > 32'(spic_pkg::PAIR_MAX)) ? spic_pkg::PAIR_MAX
                                                                       : pair_sum[spic_pkg::PAIR_W-1:0];
                    end
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (log_res.vld) begin
                    n_res.log_value   = log_res.value;
                    n_res.saturated   = log_res.sat;
                    n_res.point_count = spic_pkg::sat_cnt9(r_held);
                    n_res.pair_count  = r_pairs;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_held    <= '0;
            r_pairs   <= '0;
            r_out     <= '0;
            r_out_vld <= 1'b0;
            r_radius  <= '0;
            r_beta    <= '0;
            r_gamma   <= '0;
            r_dims    <= spic_pkg::DIMS_W'(2);
            r_lo      <= '0;
            r_hi      <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_held    <= n_held;
            r_pairs   <= n_pairs;
            r_out     <= n_out;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    spic_pkg::REG_RADIUS_SQ:  r_radius <= i_cfg_data[spic_pkg::RAD_W-1:0];
                    spic_pkg::REG_LOG_BETA:   r_beta   <= i_cfg_data[spic_pkg::LOGP_W-1:0];
                    spic_pkg::REG_LN_GAMMA:   r_gamma  <= i_cfg_data[spic_pkg::LOGP_W-1:0];
                    spic_pkg::REG_DIMS:       r_dims   <= i_cfg_data[spic_pkg::DIMS_W-1:0];
                    spic_pkg::REG_RANGE_LOW:  r_lo     <= i_cfg_data[spic_pkg::PT_W-1:0];
                    spic_pkg::REG_RANGE_HIGH: r_hi     <= i_cfg_data[spic_pkg::PT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_pt    <= n_pt;
        r_addr  <= n_addr;
        r_neigh <= n_neigh;
        r_res   <= n_res;
    end

    spic_point_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_held[spic_pkg::ADDR_W-1:0]),
        .i_wdata (r_pt),
        .i_raddr (r_addr[spic_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    spic_dist_unit u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_rd_vld),
        .i_cand     (r_pt),
        .i_stored   (ram_rdata),
        .i_dim_mask (dim_mask),
        .i_radius   (r_radius),
        .o_stat     (dist_stat)
    );

    spic_log_calc u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_a     (log_a),
        .i_b     (log_b),
        .i_beta  (r_beta),
        .i_gamma (r_gamma),
        .o_res   (log_res)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'b0, r_out.pair_count, r_out.point_count,
                         r_out.neighbor_count, r_out.log_value};
    assign o_m_tuser  = {r_out.saturated, r_out.store_full, r_out.out_of_range};

    // no store write while a read of the scan is still in flight
    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (!r_rd_vld && !dist_stat.busy))
        else $error("store written with reads pending");

    // a new item is never taken while the distance pipeline holds work
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!dist_stat.busy && !r_rd_vld))
        else $error("item accepted with distance pipeline busy");

    // held count stays within the store
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= spic_pkg::CNT_W'(spic_pkg::MAX_POINTS))
        else $error("held count beyond store depth");

    // log unit answers only while the sequencer waits for it
    a_log_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        log_res.vld |-> (r_state == S_WAIT))
        else $error("log result outside wait state");

    // scan reads never pass the held count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_held))
        else $error("scan address beyond held count");

endmodule

/* rtl/spic_point_ram.sv */
// point store: one write port, one read port with registered read data
module spic_point_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [spic_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [spic_pkg::PT_W-1:0]    i_wdata,
    input  logic [spic_pkg::ADDR_W-1:0]  i_raddr,
    output logic [spic_pkg::PT_W-1:0]    o_rdata
);

    logic [spic_pkg::PT_W-1:0] r_mem [spic_pkg::MAX_POINTS];
    logic [spic_pkg::PT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/spic_dist_unit.sv */
// two-stage squared distance and radius compare against one stored point
module spic_dist_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [spic_pkg::PT_W-1:0]      i_cand,
    input  logic [spic_pkg::PT_W-1:0]      i_stored,
    input  logic [spic_pkg::MAX_DIMS-1:0]  i_dim_mask,
    input  logic [spic_pkg::RAD_W-1:0]     i_radius,
    output spic_pkg::t_dist_stat           o_stat
);

    logic signed [spic_pkg::COORD_W:0]     diff [spic_pkg::MAX_DIMS];
    logic signed [2*spic_pkg::COORD_W+1:0] prod [spic_pkg::MAX_DIMS];
    logic [spic_pkg::SQ_W-1:0]             sq   [spic_pkg::MAX_DIMS];
    logic [spic_pkg::SUM_W-1:0]            sum;

    logic                                  r_vld1;
    logic                                  r_vld2;
    logic                                  r_hit;
    logic [spic_pkg::SQ_W-1:0]             r_sq [spic_pkg::MAX_DIMS];

    // per-lane difference and square, unused lanes give zero
    always_comb begin
        for (int d = 0; d < spic_pkg::MAX_DIMS; d++) begin
            diff[d] = $signed({i_cand[d*spic_pkg::COORD_W + spic_pkg::COORD_W-1],
                               i_cand[d*spic_pkg::COORD_W +: spic_pkg::COORD_W]})
                    - $signed({i_stored[d*spic_pkg::COORD_W + spic_pkg::COORD_W-1],
                               i_stored[d*spic_pkg::COORD_W +: spic_pkg::COORD_W]});
            prod[d] = diff[d] * diff[d];
            sq[d]   = i_dim_mask[d] ? prod[d][spic_pkg::SQ_W-1:0] : '0;
        end
    end

    always_comb begin
        sum = '0;
        for (int d = 0; d < spic_pkg::MAX_DIMS; d++) begin
            sum = sum + spic_pkg::SUM_W'(r_sq[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq  <= sq;
        r_hit <= (spic_pkg::RAD_W'(sum) < i_radius);
    end

    assign o_stat.busy    = r_vld1 | r_vld2;
    assign o_stat.hit_vld = r_vld2;
    assign o_stat.hit     = r_hit;

endmodule

/* rtl/spic_log_calc.sv */
// two-stage a*ln(beta) + b*ln(gamma) with clamp to 48 bits
module spic_log_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [spic_pkg::CNT_W-1:0]          i_a,
    input  logic [spic_pkg::PAIR_W-1:0]         i_b,
    input  logic signed [spic_pkg::LOGP_W-1:0]  i_beta,
    input  logic signed [spic_pkg::LOGP_W-1:0]  i_gamma,
    output spic_pkg::t_log_res                  o_res
);

    localparam int PA_W  = spic_pkg::CNT_W + 1 + spic_pkg::LOGP_W;
    localparam int PB_W  = spic_pkg::PAIR_W + 1 + spic_pkg::LOGP_W;
    localparam int SUM_W = spic_pkg::LOG_W + 1;

    logic signed [PA_W-1:0]  prod_a;
    logic signed [PB_W-1:0]  prod_b;
    logic signed [SUM_W-1:0] sum;

    logic                    r_vld1;
    logic                    r_vld2;
    logic signed [PA_W-1:0]  r_prod_a;
    logic signed [PB_W-1:0]  r_prod_b;
    logic                    r_sat;
    logic signed [spic_pkg::LOG_W-1:0] r_value;

    assign prod_a = $signed({1'b0, i_a}) * i_beta;
    assign prod_b = $signed({1'b0, i_b}) * i_gamma;
    assign sum    = $signed({{(SUM_W-PA_W){r_prod_a[PA_W-1]}}, r_prod_a})
                  + $signed({{(SUM_W-PB_W){r_prod_b[PB_W-1]}}, r_prod_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_start;
            r_vld2 <= r_vld1;
        end
    end

    // overflow shows as the two top bits of the sum disagreeing
    always_ff @(posedge i_clk) begin
        r_prod_a <= prod_a;
        r_prod_b <= prod_b;
        r_sat    <= (sum[SUM_W-1] != sum[SUM_W-2]);
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            r_value <= sum[SUM_W-1] ? spic_pkg::LOG_MIN : spic_pkg::LOG_MAX;
        end else begin
            r_value <= sum[spic_pkg::LOG_W-1:0];
        end
    end

    assign o_res.vld   = r_vld2;
    assign o_res.sat   = r_sat;
    assign o_res.value = r_value;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the strauss pair interaction counter
module testbench;

    // command three is not decoded, the block only reports its counts
    localparam logic [1:0]      CMD_SPARE = 2'd3;
    // register index outside the map, writes to it must change nothing
    localparam logic [spic_pkg::CIDX_W-1:0] REG_SPARE = 3'd7;

    // slowest item is a full-store compare against MAX_POINTS held points,
    // plus sender gaps and result stalls, taken many times over
    localparam int     WATCHDOG_CYCLES = 4000;
    localparam int     TAIL_CYCLES     = 300;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     FILL_PHASE      = 2;
    localparam int     ITEMS_PER_PHASE = 147;
    localparam int     FILL_INSERTS    = 270;
    localparam int     PAIR_LIMIT      = 32767;
    localparam int     CNT9_LIMIT      = 511;
    localparam longint LOGV_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LOGV_MIN        = -LOGV_MAX - 1;

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata   = '0;   // coord_0, coord_1, coord_2, coord_3
    logic [1:0]         s_tuser   = '0;   // command
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [87:0]        m_tdata;          // log_value, neighbor, point, pair counts
    logic [2:0]         m_tuser;          // out_of_range, store_full, saturated
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [spic_pkg::CIDX_W-1:0]  cfg_index = '0;
    logic [spic_pkg::CDATA_W-1:0] cfg_data  = '0;

    strauss_pair_interaction_count DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // mirror of the block state: held points, close pairs, registers
    // ------------------------------------------------------------------
    logic [spic_pkg::PT_W-1:0]   pt_mem [spic_pkg::MAX_POINTS];
    int                          held_pts   = 0;
    int                          pair_total = 0;
    logic [spic_pkg::RAD_W-1:0]  radius_r   = '0;
    logic signed [31:0]          beta_r     = '0;
    logic signed [31:0]          gamma_r    = '0;
    logic [spic_pkg::DIMS_W-1:0] dims_r     = 3'd2;
    logic [63:0]                 lo_r       = '0;
    logic [63:0]                 hi_r       = '0;

    // results still owed by the block, oldest first
    spic_pkg::t_result density_results_due [$];

    // idle pattern: 0 none, 1 sender gaps, 2 result stalls, 3 light on both
    int idle_mode    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int full_seen    = 0;
    int oor_seen     = 0;
    int settings     = 0;
    int quiet_cycles = 0;

    logic signed [15:0] ctr [spic_pkg::MAX_DIMS];   // cluster center of the current phase

    // zero acts as one dimension, anything above MAX_DIMS as MAX_DIMS
    function automatic int active_dims();
        int n;
        n = int'(dims_r);
        if (n < 1) n = 1;
        if (n > spic_pkg::MAX_DIMS) n = spic_pkg::MAX_DIMS;
        return n;
    endfunction

    // held points whose squared distance is strictly below the radius
    function automatic int close_count(logic [63:0] pt);
        int     n;
        int     nd;
        longint sum;
        longint diff;
        n  = 0;
        nd = active_dims();
        for (int i = 0; i < held_pts; i++) begin
            sum = 0;
            for (int d = 0; d < nd; d++) begin
                diff = longint'($signed(pt[16*d +: 16]))
                     - longint'($signed(pt_mem[i][16*d +: 16]));
                sum += diff * diff;
            end
            if (sum < longint'(radius_r)) n++;
        end
        return n;
    endfunction

    function automatic longint clamp_log(input longint v, output logic sat);
        sat = 1'b0;
        if (v > LOGV_MAX) begin
            sat = 1'b1;
            return LOGV_MAX;
        end
        if (v < LOGV_MIN) begin
            sat = 1'b1;
            return LOGV_MIN;
        end
        return v;
    endfunction

    // one command applied to the mirrored state, returns the result it owes
    function automatic spic_pkg::t_result strauss_eval(logic [1:0] cmd, logic [63:0] pt);
        spic_pkg::t_result  r;
        longint             logv;
        int                 neigh;
        logic               oor;
        logic               full;
        logic               sat;
        logic signed [15:0] c;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logv  = 0;
        neigh = 0;
        oor   = 1'b0;
        full  = 1'b0;
        sat   = 1'b0;
        case (cmd)
            spic_pkg::CMD_CLEAR: begin
                held_pts   = 0;
                pair_total = 0;
            end
            spic_pkg::CMD_INSERT: begin
                if (held_pts >= spic_pkg::MAX_POINTS) begin
                    // refused: state kept, density of the current set
                    full = 1'b1;
                end else begin
                    neigh      = close_count(pt);
                    pair_total = (pair_total + neigh > PAIR_LIMIT) ? PAIR_LIMIT
                                                                   : pair_total + neigh;
                    pt_mem[held_pts] = pt;
                    held_pts++;
                end
                logv = clamp_log(longint'(held_pts) * longint'(beta_r)
                               + longint'(pair_total) * longint'(gamma_r), sat);
            end
            spic_pkg::CMD_QUERY: begin
                for (int d = 0; d < active_dims(); d++) begin
                    c  = pt[16*d +: 16];
                    lo = lo_r[16*d +: 16];
                    hi = hi_r[16*d +: 16];
                    if (c < lo || c > hi) oor = 1'b1;
                end
                if (oor) begin
                    logv = LOGV_MIN;
                end else begin
                    neigh = close_count(pt);
                    logv  = clamp_log(longint'(neigh) * longint'(gamma_r), sat);
                end
            end
            default: ;
        endcase
        r.log_value      = logv[spic_pkg::LOG_W-1:0];
        r.neighbor_count = (neigh > CNT9_LIMIT) ? 9'd511 : spic_pkg::CNT9_W'(neigh);
        r.point_count    = (held_pts > CNT9_LIMIT) ? 9'd511 : spic_pkg::CNT9_W'(held_pts);
        r.pair_count     = spic_pkg::PAIR_W'(pair_total);
        r.out_of_range   = oor;
        r.store_full     = full;
        r.saturated      = sat;
        return r;
    endfunction

    // result that can be read off directly: log value, point count, range flag
    function automatic spic_pkg::t_result mk_res(longint logv, int pts, logic oor);
        spic_pkg::t_result r;
        r              = '0;
        r.log_value    = logv[spic_pkg::LOG_W-1:0];
        r.point_count  = spic_pkg::CNT9_W'(pts);
        r.out_of_range = oor;
        return r;
    endfunction

    function automatic logic [63:0] pt4(logic [15:0] c0, logic [15:0] c1,
                                        logic [15:0] c2, logic [15:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic bit sender_holds();
        case (idle_mode)
            1:       return $urandom_range(0, 99) < 71;
            3:       return $urandom_range(0, 99) < 6;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            2:       return $urandom_range(0, 99) < 71;
            3:       return $urandom_range(0, 99) < 6;
            default: return 1'b0;
        endcase
    endfunction

    // mostly near the phase center so that neighbors and bounds both matter
    function automatic logic [15:0] rand_coord(int d);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return ctr[d] + 16'($urandom_range(0, 120)) - 16'd60;
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] rand_point();
        return {rand_coord(3), rand_coord(2), rand_coord(1), rand_coord(0)};
    endfunction

    function automatic logic [1:0] rand_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return spic_pkg::CMD_CLEAR;
        if (r < 8) return CMD_SPARE;
        if (r < 54) return spic_pkg::CMD_INSERT;
        return spic_pkg::CMD_QUERY;
    endfunction

    function automatic logic [31:0] rand_log();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [spic_pkg::RAD_W-1:0] rand_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return 36'd1;
        if (r < 70) return 36'($urandom_range(50, 30000));
        if (r < 85) return {4'($urandom), 32'($urandom)};
        return '1;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers: inputs move on the falling edge, handshakes are
    // sampled on the rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic [63:0] pt,
                             input logic typed, input spic_pkg::t_result want);
        spic_pkg::t_result due;
        while (sender_holds()) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pt;
        do @(posedge i_clk); while (!s_tready);
        // the mirror always advances, a typed row only overrides what is owed
        due = strauss_eval(cmd, pt);
        density_results_due.push_back(typed ? want : due);
        items_sent++;
        @(negedge i_clk);
    endtask

    // every command owes a result, so an empty list means the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (density_results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [spic_pkg::CIDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            spic_pkg::REG_RADIUS_SQ:  radius_r = val[spic_pkg::RAD_W-1:0];
            spic_pkg::REG_LOG_BETA:   beta_r   = val[31:0];
            spic_pkg::REG_LN_GAMMA:   gamma_r  = val[31:0];
            spic_pkg::REG_DIMS:       dims_r   = val[spic_pkg::DIMS_W-1:0];
            spic_pkg::REG_RANGE_LOW:  lo_r     = val;
            spic_pkg::REG_RANGE_HIGH: hi_r     = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // full register set, unused upper data bits carry junk the block must drop
    task automatic apply_setting(input logic [spic_pkg::RAD_W-1:0] radius,
                                 input logic [31:0] beta,
                                 input logic [31:0] gamma,
                                 input logic [spic_pkg::DIMS_W-1:0] dims,
                                 input logic [63:0] lo, input logic [63:0] hi,
                                 input logic spare_write);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        settle();
        write_reg(spic_pkg::REG_RADIUS_SQ, {junk[63:spic_pkg::RAD_W], radius});
        write_reg(spic_pkg::REG_LOG_BETA, {junk[63:32], beta});
        write_reg(spic_pkg::REG_LN_GAMMA, {junk[31:0], gamma});
        write_reg(spic_pkg::REG_DIMS, {junk[63:spic_pkg::DIMS_W], dims});
        write_reg(spic_pkg::REG_RANGE_LOW, lo);
        write_reg(spic_pkg::REG_RANGE_HIGH, hi);
        if (spare_write) write_reg(REG_SPARE, junk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        m_tready <= !receiver_stalls();
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        spic_pkg::t_result got;
        spic_pkg::t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.log_value      = m_tdata[spic_pkg::LOG_W-1:0];
            got.neighbor_count = m_tdata[spic_pkg::LOG_W +: spic_pkg::CNT9_W];
            got.point_count    = m_tdata[spic_pkg::LOG_W+spic_pkg::CNT9_W +: spic_pkg::CNT9_W];
            got.pair_count     = m_tdata[spic_pkg::LOG_W+2*spic_pkg::CNT9_W +: spic_pkg::PAIR_W];
            got.out_of_range   = m_tuser[0];
            got.store_full     = m_tuser[1];
            got.saturated      = m_tuser[2];
            if (density_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with nothing owed: log %0d points %0d",
                             got.log_value, got.point_count);
            end else begin
                want = density_results_due.pop_front();
                results_seen++;
                if (want.store_full) full_seen++;
                if (want.out_of_range) oor_seen++;
                if (got.log_value !== want.log_value
                    || got.neighbor_count !== want.neighbor_count
                    || got.point_count !== want.point_count
                    || got.pair_count !== want.pair_count
                    || got.out_of_range !== want.out_of_range
                    || got.store_full !== want.store_full
                    || got.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d (expected/actual): log %0d/%0d nbr %0d/%0d",
                                 results_seen, want.log_value, got.log_value,
                                 want.neighbor_count, got.neighbor_count);
                        $display("  pts %0d/%0d pairs %0d/%0d oor,full,sat %b%b%b/%b%b%b",
                                 want.point_count, got.point_count,
                                 want.pair_count, got.pair_count,
                                 want.out_of_range, want.store_full, want.saturated,
                                 got.out_of_range, got.store_full, got.saturated);
                    end
                end
            end
        end
    end

    // no handshake on any channel for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("no handshake for %0d cycles, %0d results still owed",
                     quiet_cycles, density_results_due.size());
            $display("strauss_pair_interaction_count test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    typedef struct packed {
        logic              reconfig;  // load the corner setting before this row
        logic [1:0]        cmd;
        logic [63:0]       pt;
        logic              typed;     // result below is owed as written
        spic_pkg::t_result want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    initial begin
        int                          n_ins;
        int                          r;
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        logic [spic_pkg::DIMS_W-1:0] dims;
        logic signed [15:0]          lo_d;
        logic signed [15:0]          hi_d;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: radius 0, logs 0, two dims, bounds [0, 0]
        dir_rows.push_back('{1'b0, spic_pkg::CMD_CLEAR, 64'h0, 1'b1, mk_res(0, 0, 1'b0)});
        // spare command reports counts only
        dir_rows.push_back('{1'b0, CMD_SPARE, '1, 1'b1, mk_res(0, 0, 1'b0)});
        // dims 2 and 3 lie outside the used dims, so no bound check on them
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, pt4(16'h0, 16'h0, 16'd5, 16'hFFFB),
                             1'b1, mk_res(0, 0, 1'b0)});
        // above the high bound, then below the low bound
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, pt4(16'd1, 16'h0, 16'h0, 16'h0),
                             1'b1, mk_res(LOGV_MIN, 0, 1'b1)});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, pt4(16'h0, 16'hFFFF, 16'h0, 16'h0),
                             1'b1, mk_res(LOGV_MIN, 0, 1'b1)});
        // radius 0: even identical points are not close
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT, 64'h0, 1'b1, mk_res(0, 1, 1'b0)});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT,
                             pt4(16'h0, 16'h0, 16'h7FFF, 16'h8000),
                             1'b1, mk_res(0, 2, 1'b0)});
        // corner setting: widest radius, extreme logs, four dims, full bounds
        dir_rows.push_back('{1'b1, spic_pkg::CMD_CLEAR, '1, 1'b1, mk_res(0, 0, 1'b0)});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT, {4{16'h8000}}, 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT, {4{16'h7FFF}}, 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT,
                             pt4(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000), 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT,
                             pt4(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, 64'h0, 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, {4{16'h7FFF}}, 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_QUERY, {4{16'h8000}}, 1'b0, '0});
        dir_rows.push_back('{1'b0, CMD_SPARE, {4{16'h5555}}, 1'b0, '0});
        dir_rows.push_back('{1'b0, spic_pkg::CMD_INSERT,
                             pt4(16'd1, 16'hFFFF, 16'd2, 16'hFFFE), 1'b0, '0});

        idle_mode = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].reconfig)
                apply_setting('1, 32'h7FFF_FFFF, 32'h8000_0000, 3'd4,
                              {4{16'h8000}}, {4{16'h7FFF}}, 1'b0);
            send_item(dir_rows[k].cmd, dir_rows[k].pt, dir_rows[k].typed, dir_rows[k].want);
        end

        // random phases, each under its own setting and idle pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int d = 0; d < spic_pkg::MAX_DIMS; d++)
                ctr[d] = 16'($urandom_range(0, 60000)) - 16'sd30000;
            for (int d = 0; d < spic_pkg::MAX_DIMS; d++) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    lo_d = 16'sh8000;
                    hi_d = 16'sh7FFF;
                end else if (r < 25) begin
                    lo_d = 16'($urandom);
                    hi_d = 16'($urandom);
                end else begin
                    lo_d = ctr[d] - 16'($urandom_range(0, 80));
                    hi_d = ctr[d] + 16'($urandom_range(0, 80));
                end
                lo[16*d +: 16] = lo_d;
                hi[16*d +: 16] = hi_d;
            end
            // out-of-map dims counts (0, 5..7) show up now and then
            dims = ($urandom_range(0, 99) < 60) ? 3'($urandom_range(1, 4))
                                                 : 3'($urandom_range(0, 7));
            apply_setting(rand_radius(), rand_log(), rand_log(), dims, lo, hi,
                          phase == 0);
            idle_mode = phase % 4;

            if (phase == FILL_PHASE) begin
                // fill the store to the top, then keep knocking on it
                send_item(spic_pkg::CMD_CLEAR, rand_point(), 1'b0, '0);
                n_ins = 0;
                while (n_ins < FILL_INSERTS) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_item(spic_pkg::CMD_QUERY, rand_point(), 1'b0, '0);
                    end else begin
                        send_item(spic_pkg::CMD_INSERT, rand_point(), 1'b0, '0);
                        n_ins++;
                    end
                end
            end else begin
                for (int k = 0; k < ITEMS_PER_PHASE; k++)
                    send_item(rand_command(), rand_point(), 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("sent %0d command items, checked %0d results across %0d register settings",
                 items_sent, results_seen, settings);
        $display("saw %0d refused inserts and %0d out-of-range queries, %0d mismatches",
                 full_seen, oor_seen, mismatches);
        if (mismatches == 0 && density_results_due.size() == 0)
            $display("strauss_pair_interaction_count test passed");
        else
            $display("strauss_pair_interaction_count test failed");
        $finish;
    end

endmodule
